### rtl/fly_camera_orientation_update_top_macros.svh
// assertion macros shared by the camera update rtl
`ifndef FLY_CAMERA_ORIENTATION_UPDATE_TOP_MACROS_SVH
`define FLY_CAMERA_ORIENTATION_UPDATE_TOP_MACROS_SVH

// condition holds at every edge out of reset
`define FCOU_ASSERT_ALWAYS(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// consequence holds in the same cycle
`define FCOU_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// consequence holds in the next cycle
`define FCOU_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### rtl/fcou_pkg.sv
// types, constants and tables of the camera update block
package fcou_pkg;

	localparam int MOUSE_W    = 13;
	localparam int MOVE_W     = 2;
	localparam int SENS_W     = 16;
	localparam int SPEED_W    = 24;
	localparam int SCREEN_W   = 14;
	localparam int POS_W      = 32;
	localparam int VEC_W      = 16;
	localparam int ANGLE_W    = 32;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 24;

	localparam int CORDIC_STEPS = 16;
	localparam int XY_W         = 34;
	localparam int MV_W         = 18;
	localparam int LEN_W        = 17;
	localparam int NUM_W        = 41;
	localparam int SQ_W         = 36;
	localparam int ROOT_STEPS   = 18;

	localparam logic [CFG_IDX_W-1:0] REG_SENSITIVITY   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SPEED         = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SCREEN_WIDTH  = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SCREEN_HEIGHT = 2'd3;

	localparam logic [MOVE_W-1:0] MOVE_POS = 2'b01;
	localparam logic [MOVE_W-1:0] MOVE_NEG = 2'b11;

	localparam logic [SENS_W-1:0]   SENS_RST   = 16'd6554;
	localparam logic [SPEED_W-1:0]  SPEED_RST  = 24'd3277;
	localparam logic [SCREEN_W-1:0] WIDTH_RST  = 14'd1280;
	localparam logic [SCREEN_W-1:0] HEIGHT_RST = 14'd720;

	localparam logic signed [ANGLE_W-1:0] QUARTER_TURN = 32'sd5898240;
	localparam logic signed [ANGLE_W-1:0] HALF_TURN    = 32'sd11796480;
	localparam logic [ANGLE_W-1:0]        FULL_TURN    = 32'd23592960;
	localparam logic signed [ANGLE_W-1:0] PITCH_LIMIT  = 32'sd5897585;
	localparam logic signed [ANGLE_W-1:0] YAW_RST      = -32'sd5898240;

	localparam logic signed [XY_W-1:0]  CORDIC_GAIN = 34'sd652032874;
	localparam logic signed [VEC_W-1:0] ONE_Q14     = 16'sd16384;

	localparam logic signed [POS_W-1:0] POS_X_RST = 32'sd0;
	localparam logic signed [POS_W-1:0] POS_Y_RST = 32'sd65536;
	localparam logic signed [POS_W-1:0] POS_Z_RST = -32'sd327680;

	typedef enum logic {
		OP_SQRT,
		OP_DIV
	} rd_op_t;

	typedef struct packed {
		logic   start;
		rd_op_t op;
	} rd_req_t;

	// arctangent of 2^-i in Q16 degrees
	function automatic logic signed [ANGLE_W-1:0] atan_q16(input logic [3:0] i);
		logic signed [ANGLE_W-1:0] r;
		case (i)
			4'd0:    r = 32'sd2949120;
			4'd1:    r = 32'sd1740967;
			4'd2:    r = 32'sd919879;
			4'd3:    r = 32'sd466945;
			4'd4:    r = 32'sd234379;
			4'd5:    r = 32'sd117304;
			4'd6:    r = 32'sd58666;
			4'd7:    r = 32'sd29335;
			4'd8:    r = 32'sd14668;
			4'd9:    r = 32'sd7334;
			4'd10:   r = 32'sd3667;
			4'd11:   r = 32'sd1833;
			4'd12:   r = 32'sd917;
			4'd13:   r = 32'sd458;
			4'd14:   r = 32'sd229;
			4'd15:   r = 32'sd115;
			default: r = 32'sd0;
		endcase
		return r;
	endfunction

	// multiple of a full turn used by the wrap reduction
	function automatic logic [ANGLE_W-1:0] turn_mult(input logic [2:0] k);
		return FULL_TURN << k;
	endfunction

endpackage

### rtl/fcou_frame_if.sv
// frame item channel: mouse position and move codes
interface fcou_frame_if;
	logic                               valid;
	logic                               ready;
	logic        [fcou_pkg::MOUSE_W-1:0] mouse_x;
	logic        [fcou_pkg::MOUSE_W-1:0] mouse_y;
	logic signed [fcou_pkg::MOVE_W-1:0]  move_x;
	logic signed [fcou_pkg::MOVE_W-1:0]  move_y;
	logic signed [fcou_pkg::MOVE_W-1:0]  move_z;

	modport source (output valid, mouse_x, mouse_y, move_x, move_y, move_z, input ready);
	modport sink (input valid, mouse_x, mouse_y, move_x, move_y, move_z, output ready);
endinterface

### rtl/fcou_pose_if.sv
// pose result channel: position and front vector
interface fcou_pose_if;
	logic                             valid;
	logic                             ready;
	logic signed [fcou_pkg::POS_W-1:0] pos_x;
	logic signed [fcou_pkg::POS_W-1:0] pos_y;
	logic signed [fcou_pkg::POS_W-1:0] pos_z;
	logic signed [fcou_pkg::VEC_W-1:0] front_x;
	logic signed [fcou_pkg::VEC_W-1:0] front_y;
	logic signed [fcou_pkg::VEC_W-1:0] front_z;

	modport source (output valid, pos_x, pos_y, pos_z, front_x, front_y, front_z, input ready);
	modport sink (input valid, pos_x, pos_y, pos_z, front_x, front_y, front_z, output ready);
endinterface

### rtl/fcou_cordic.sv
// iterative rotation cordic giving cosine and sine of an angle in degrees
module fcou_cordic (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   start,
	input  logic signed [fcou_pkg::ANGLE_W-1:0]    angle,
	output logic                                   done,
	output logic signed [fcou_pkg::VEC_W-1:0]      cos_val,
	output logic signed [fcou_pkg::VEC_W-1:0]      sin_val
);

	logic signed [fcou_pkg::XY_W-1:0]    x_q, y_q, dx, dy;
	logic signed [fcou_pkg::ANGLE_W-1:0] z_q, z_init, at;
	logic                                flip_init, flip_q, busy_q, done_q;
	logic [3:0]                          i_q;
	logic signed [fcou_pkg::VEC_W-1:0]   cr, sr;

	// round q4.30 to q2.14 and clamp to unit
	function automatic logic signed [fcou_pkg::VEC_W-1:0] to_q14(
		input logic signed [fcou_pkg::XY_W-1:0] v);
		logic signed [fcou_pkg::XY_W-1:0] t;
		logic signed [fcou_pkg::VEC_W-1:0] r;
		t = (v + 34'sd32768) >>> 16;
		if (t > 34'sd16384) r = fcou_pkg::ONE_Q14;
		else if (t < -34'sd16384) r = -fcou_pkg::ONE_Q14;
		else r = t[fcou_pkg::VEC_W-1:0];
		return r;
	endfunction

	// fold into +-90 degrees, results negated when folded
	always_comb begin
		flip_init = 1'b0;
		z_init    = angle;
		if (angle > fcou_pkg::QUARTER_TURN) begin
			z_init    = angle - fcou_pkg::HALF_TURN;
			flip_init = 1'b1;
		end else if (angle < -fcou_pkg::QUARTER_TURN) begin
			z_init    = angle + fcou_pkg::HALF_TURN;
			flip_init = 1'b1;
		end
	end

	assign dx = y_q >>> i_q;
	assign dy = x_q >>> i_q;
	assign at = fcou_pkg::atan_q16(i_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			i_q    <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				i_q    <= '0;
			end else if (busy_q) begin
				i_q <= i_q + 4'd1;
				if (i_q == 4'(fcou_pkg::CORDIC_STEPS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			x_q    <= fcou_pkg::CORDIC_GAIN;
			y_q    <= '0;
			z_q    <= z_init;
			flip_q <= flip_init;
		end else if (busy_q) begin
			if (z_q >= 0) begin
				x_q <= x_q - dx;
				y_q <= y_q + dy;
				z_q <= z_q - at;
			end else begin
				x_q <= x_q + dx;
				y_q <= y_q - dy;
				z_q <= z_q + at;
			end
		end
	end

	assign cr      = to_q14(x_q);
	assign sr      = to_q14(y_q);
	assign cos_val = flip_q ? -cr : cr;
	assign sin_val = flip_q ? -sr : sr;
	assign done    = done_q;

endmodule

### rtl/fcou_rootdiv.sv
// shift-subtract unit: integer square root or restoring division
module fcou_rootdiv (
	input  logic                           clk,
	input  logic                           arst_n,
	input  fcou_pkg::rd_req_t              req,
	input  logic [fcou_pkg::NUM_W-1:0]     a,
	input  logic [fcou_pkg::LEN_W-1:0]     d,
	output logic                           done,
	output logic [fcou_pkg::POS_W-1:0]     res
);

	logic [fcou_pkg::NUM_W-1:0] acc_q;
	logic [fcou_pkg::SQ_W-1:0]  r_q, bit_q, trial;
	logic [fcou_pkg::LEN_W-1:0] rem_q, d_q;
	logic [fcou_pkg::LEN_W:0]   rem_sh;
	logic [5:0]                 cnt_q;
	logic                       busy_q, done_q;
	fcou_pkg::rd_op_t           op_q;

	assign trial  = r_q + bit_q;
	assign rem_sh = {rem_q, acc_q[fcou_pkg::NUM_W-1]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
			op_q   <= fcou_pkg::OP_SQRT;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				op_q   <= req.op;
				cnt_q  <= (req.op == fcou_pkg::OP_SQRT) ? 6'(fcou_pkg::ROOT_STEPS - 1)
				                                        : 6'(fcou_pkg::NUM_W - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 6'd1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			acc_q <= a;
			d_q   <= d;
			rem_q <= '0;
			r_q   <= '0;
			bit_q <= {2'b01, {(fcou_pkg::SQ_W-2){1'b0}}};
		end else if (busy_q) begin
			if (op_q == fcou_pkg::OP_SQRT) begin
				bit_q <= bit_q >> 2;
				if (acc_q >= {{(fcou_pkg::NUM_W-fcou_pkg::SQ_W){1'b0}}, trial}) begin
					acc_q <= acc_q - {{(fcou_pkg::NUM_W-fcou_pkg::SQ_W){1'b0}}, trial};
					r_q   <= (r_q >> 1) + bit_q;
				end else begin
					r_q <= r_q >> 1;
				end
			end else begin
				if (rem_sh >= {1'b0, d_q}) begin
					rem_q <= fcou_pkg::LEN_W'(rem_sh - {1'b0, d_q});
					acc_q <= {acc_q[fcou_pkg::NUM_W-2:0], 1'b1};
				end else begin
					rem_q <= rem_sh[fcou_pkg::LEN_W-1:0];
					acc_q <= {acc_q[fcou_pkg::NUM_W-2:0], 1'b0};
				end
			end
		end
	end

	assign done = done_q;
	assign res  = (op_q == fcou_pkg::OP_SQRT) ? r_q[fcou_pkg::POS_W-1:0]
	                                          : acc_q[fcou_pkg::POS_W-1:0];

endmodule

### rtl/fly_camera_orientation_update_top.sv
// top level of the first-person camera update: sequencer, datapath and output register
//
// frame channel: one transaction per rendered frame, carrying the mouse position
// and a -1/0/+1 move code per axis. frame.ready is high only while the sequencer
// is idle; the block works on one frame at a time.
// pose channel: one transaction per frame with the Q16.16 position and the Q2.14
// front vector, held in an output register until pose.ready takes it.
// config: cfg_we writes cfg_data into the register picked by cfg_index
// (sensitivity, speed, screen width, screen height); write only while idle.
// a zero move vector skips the length root and the position divides. the shared
// cordic runs twice per frame, pitch then yaw; the shift-subtract unit gives the
// length root and then each of the three position divides; the other products
// go through the shared multiplier. frame.ready returns in the same cycle that the
// pose is loaded into the output register.
// the first frame after reset takes the screen center as the previous mouse spot.
// reset: angles, position and registers go to their defaults at once, no sweep.
// stall: a finished pose waits in the output register; the next frame may be
// taken meanwhile, but its pose is held back until the previous one is taken.
`include "fly_camera_orientation_update_top_macros.svh"

module fly_camera_orientation_update_top (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [fcou_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [fcou_pkg::CFG_DATA_W-1:0]     cfg_data,
	fcou_frame_if.sink                          frame,
	fcou_pose_if.source                         pose
);

	typedef enum logic [15:0] {
		S_IDLE  = 16'h0001,
		S_DX    = 16'h0002,
		S_DY    = 16'h0004,
		S_ANG   = 16'h0008,
		S_MOD   = 16'h0010,
		S_CP    = 16'h0020,
		S_CY    = 16'h0040,
		S_F0    = 16'h0080,
		S_F2    = 16'h0100,
		S_MV    = 16'h0200,
		S_SQ    = 16'h0400,
		S_ROOT  = 16'h0800,
		S_RWAIT = 16'h1000,
		S_NUM   = 16'h2000,
		S_DIV   = 16'h4000,
		S_OUT   = 16'h8000
	} state_t;

	state_t state_q;

	// configuration registers
	logic [fcou_pkg::SENS_W-1:0]   sens_q;
	logic [fcou_pkg::SPEED_W-1:0]  speed_q;
	logic [fcou_pkg::SCREEN_W-1:0] width_q, height_q;

	// frame item held for the whole update
	logic [fcou_pkg::MOUSE_W-1:0]  mx_q, my_q, last_x_q, last_y_q;
	logic [fcou_pkg::MOVE_W-1:0]   mvx_q, mvy_q, mvz_q;
	logic                          primed_q;

	// angle and vector state
	logic signed [fcou_pkg::ANGLE_W-1:0] yaw_q, pitch_q, dxp_q, dyp_q;
	logic [fcou_pkg::ANGLE_W-1:0]        red_q, red_mod;
	logic [2:0]                          mod_k_q;
	logic signed [fcou_pkg::VEC_W-1:0]   cp_q, sp_q, cy_q, sy_q, f0_q, f2_q;
	logic signed [fcou_pkg::MV_W-1:0]    m_q [3];
	logic signed [fcou_pkg::MV_W-1:0]    m_sel;
	logic [fcou_pkg::LEN_W-1:0]          mag, len_q;
	logic [fcou_pkg::SQ_W-1:0]           sq_q;
	logic [1:0]                          k_q;
	logic signed [fcou_pkg::POS_W-1:0]   pos_q [3];
	logic signed [fcou_pkg::POS_W-1:0]   step;

	// output register
	logic                                ov_q;
	logic signed [fcou_pkg::POS_W-1:0]   opx_q, opy_q, opz_q;
	logic signed [fcou_pkg::VEC_W-1:0]   ofx_q, ofy_q, ofz_q;

	// shared multiplier
	logic signed [17:0] ma;
	logic signed [24:0] mb;
	logic signed [42:0] prod, prod_rnd;
	logic signed [13:0] dmx, dmy;

	// angle update terms
	logic signed [32:0] ysum, psum;

	// move vector terms
	logic signed [fcou_pkg::MV_W-1:0] fx_e, fy_e, fz_e, mvec [3];

	// shared units
	logic                                c_start, c_done;
	logic signed [fcou_pkg::ANGLE_W-1:0] c_angle;
	logic signed [fcou_pkg::VEC_W-1:0]   c_cos, c_sin;
	fcou_pkg::rd_req_t                   rd_req;
	logic [fcou_pkg::NUM_W-1:0]          rd_a;
	logic                                rd_done;
	logic [fcou_pkg::POS_W-1:0]          rd_res;

	logic accept, pose_take;

	function automatic logic signed [fcou_pkg::MV_W-1:0] MV_EXT(
		input logic signed [fcou_pkg::VEC_W-1:0] v);
		return {{(fcou_pkg::MV_W-fcou_pkg::VEC_W){v[fcou_pkg::VEC_W-1]}}, v};
	endfunction

	assign accept    = frame.valid && frame.ready;
	assign pose_take = pose.valid && pose.ready;
	assign frame.ready = (state_q == S_IDLE);

	// mouse deltas against the previous position
	assign dmx = $signed({1'b0, mx_q}) - $signed({1'b0, last_x_q});
	assign dmy = $signed({1'b0, my_q}) - $signed({1'b0, last_y_q});

	assign m_sel = m_q[k_q];
	assign mag   = m_sel[fcou_pkg::MV_W-1] ? fcou_pkg::LEN_W'(-m_sel)
	                                       : fcou_pkg::LEN_W'(m_sel);

	always_comb begin
		ma = '0;
		mb = '0;
		case (state_q)
			S_DX: begin
				ma = {{4{dmx[13]}}, dmx};
				mb = $signed({9'b0, sens_q});
			end
			S_DY: begin
				ma = {{4{dmy[13]}}, dmy};
				mb = $signed({9'b0, sens_q});
			end
			S_F0: begin
				ma = {{2{cp_q[15]}}, cp_q};
				mb = {{9{cy_q[15]}}, cy_q};
			end
			S_F2: begin
				ma = {{2{cp_q[15]}}, cp_q};
				mb = {{9{sy_q[15]}}, sy_q};
			end
			S_SQ: begin
				ma = m_sel;
				mb = {{7{m_sel[17]}}, m_sel};
			end
			S_NUM: begin
				ma = $signed({1'b0, mag});
				mb = $signed({1'b0, speed_q});
			end
			default: begin
				ma = '0;
				mb = '0;
			end
		endcase
	end

	assign prod     = ma * mb;
	assign prod_rnd = prod + 43'sd8192;

	// yaw sum shifted by half a turn, lifted above zero by 32 turns
	always_comb begin
		ysum = $signed({yaw_q[31], yaw_q}) + $signed({dxp_q[31], dxp_q})
		     + $signed({1'b0, fcou_pkg::HALF_TURN});
		if (ysum < 0)
			ysum = ysum + $signed({1'b0, fcou_pkg::turn_mult(3'd5)});
		psum = $signed({pitch_q[31], pitch_q}) - $signed({dyp_q[31], dyp_q});
	end

	assign red_mod = (red_q >= fcou_pkg::turn_mult(mod_k_q)) ?
	                 red_q - fcou_pkg::turn_mult(mod_k_q) : red_q;

	// front, strafe and up contributions by move code
	always_comb begin
		fx_e = '0;
		fy_e = '0;
		fz_e = '0;
		if (mvz_q == fcou_pkg::MOVE_NEG) begin
			fx_e = MV_EXT(f0_q);
			fy_e = MV_EXT(sp_q);
			fz_e = MV_EXT(f2_q);
		end else if (mvz_q == fcou_pkg::MOVE_POS) begin
			fx_e = -MV_EXT(f0_q);
			fy_e = -MV_EXT(sp_q);
			fz_e = -MV_EXT(f2_q);
		end
		mvec[0] = fx_e;
		mvec[1] = fy_e;
		mvec[2] = fz_e;
		if (mvx_q == fcou_pkg::MOVE_POS) begin
			mvec[0] = mvec[0] - MV_EXT(f2_q);
			mvec[2] = mvec[2] + MV_EXT(f0_q);
		end else if (mvx_q == fcou_pkg::MOVE_NEG) begin
			mvec[0] = mvec[0] + MV_EXT(f2_q);
			mvec[2] = mvec[2] - MV_EXT(f0_q);
		end
		if (mvy_q == fcou_pkg::MOVE_POS)
			mvec[1] = mvec[1] + MV_EXT(fcou_pkg::ONE_Q14);
		else if (mvy_q == fcou_pkg::MOVE_NEG)
			mvec[1] = mvec[1] - MV_EXT(fcou_pkg::ONE_Q14);
	end

	// cordic runs pitch at the end of the wrap, then yaw
	assign c_start = ((state_q == S_MOD) && (mod_k_q == 3'd0)) ||
	                 ((state_q == S_CP) && c_done);
	assign c_angle = (state_q == S_MOD) ? pitch_q : yaw_q;

	always_comb begin
		rd_req.start = 1'b0;
		rd_req.op    = fcou_pkg::OP_SQRT;
		rd_a         = {{(fcou_pkg::NUM_W-fcou_pkg::SQ_W){1'b0}}, sq_q};
		if ((state_q == S_ROOT) && (sq_q != '0)) begin
			rd_req.start = 1'b1;
		end else if (state_q == S_NUM) begin
			rd_req.start = 1'b1;
			rd_req.op    = fcou_pkg::OP_DIV;
			rd_a         = fcou_pkg::NUM_W'(prod[39:0])
			             + {{(fcou_pkg::NUM_W-fcou_pkg::LEN_W){1'b0}}, len_q >> 1};
		end
	end

	assign step = m_sel[fcou_pkg::MV_W-1] ? -$signed(rd_res) : $signed(rd_res);

	fcou_cordic u_cordic (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (c_start),
		.angle   (c_angle),
		.done    (c_done),
		.cos_val (c_cos),
		.sin_val (c_sin)
	);

	fcou_rootdiv u_rootdiv (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (rd_req),
		.a      (rd_a),
		.d      (len_q),
		.done   (rd_done),
		.res    (rd_res)
	);

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sens_q   <= fcou_pkg::SENS_RST;
			speed_q  <= fcou_pkg::SPEED_RST;
			width_q  <= fcou_pkg::WIDTH_RST;
			height_q <= fcou_pkg::HEIGHT_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				fcou_pkg::REG_SENSITIVITY:   sens_q   <= cfg_data[fcou_pkg::SENS_W-1:0];
				fcou_pkg::REG_SPEED:         speed_q  <= cfg_data[fcou_pkg::SPEED_W-1:0];
				fcou_pkg::REG_SCREEN_WIDTH:  width_q  <= cfg_data[fcou_pkg::SCREEN_W-1:0];
				fcou_pkg::REG_SCREEN_HEIGHT: height_q <= cfg_data[fcou_pkg::SCREEN_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// sequencer and camera state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			primed_q <= 1'b0;
			last_x_q <= '0;
			last_y_q <= '0;
			yaw_q    <= fcou_pkg::YAW_RST;
			pitch_q  <= '0;
			pos_q[0] <= fcou_pkg::POS_X_RST;
			pos_q[1] <= fcou_pkg::POS_Y_RST;
			pos_q[2] <= fcou_pkg::POS_Z_RST;
			mod_k_q  <= '0;
			k_q      <= '0;
			ov_q     <= 1'b0;
		end else begin
			// output register loads a new pose or empties when taken
			if ((state_q == S_OUT) && (!ov_q || pose.ready))
				ov_q <= 1'b1;
			else if (pose_take)
				ov_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (!primed_q) begin
							last_x_q <= width_q[fcou_pkg::MOUSE_W:1];
							last_y_q <= height_q[fcou_pkg::MOUSE_W:1];
						end
						primed_q <= 1'b1;
						state_q  <= S_DX;
					end
				end
				S_DX: state_q <= S_DY;
				S_DY: begin
					last_x_q <= mx_q;
					last_y_q <= my_q;
					state_q  <= S_ANG;
				end
				S_ANG: begin
					if (psum > $signed({fcou_pkg::PITCH_LIMIT[31], fcou_pkg::PITCH_LIMIT}))
						pitch_q <= fcou_pkg::PITCH_LIMIT;
					else if (psum < -$signed({fcou_pkg::PITCH_LIMIT[31],
					                          fcou_pkg::PITCH_LIMIT}))
						pitch_q <= -fcou_pkg::PITCH_LIMIT;
					else
						pitch_q <= psum[31:0];
					mod_k_q <= 3'd5;
					state_q <= S_MOD;
				end
				S_MOD: begin
					mod_k_q <= mod_k_q - 3'd1;
					if (mod_k_q == 3'd0) begin
						yaw_q   <= $signed(red_mod) - fcou_pkg::HALF_TURN;
						state_q <= S_CP;
					end
				end
				S_CP: if (c_done) state_q <= S_CY;
				S_CY: if (c_done) state_q <= S_F0;
				S_F0: state_q <= S_F2;
				S_F2: state_q <= S_MV;
				S_MV: begin
					k_q     <= '0;
					state_q <= S_SQ;
				end
				S_SQ: begin
					if (k_q == 2'd2) begin
						k_q     <= '0;
						state_q <= S_ROOT;
					end else begin
						k_q <= k_q + 2'd1;
					end
				end
				S_ROOT: state_q <= (sq_q == '0) ? S_OUT : S_RWAIT;
				S_RWAIT: begin
					if (rd_done) begin
						k_q     <= '0;
						state_q <= S_NUM;
					end
				end
				S_NUM: state_q <= S_DIV;
				S_DIV: begin
					if (rd_done) begin
						pos_q[k_q] <= pos_q[k_q] + step;
						if (k_q == 2'd2) begin
							state_q <= S_OUT;
						end else begin
							k_q     <= k_q + 2'd1;
							state_q <= S_NUM;
						end
					end
				end
				S_OUT: begin
					if (!ov_q || pose.ready)
						state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// datapath registers, no reset needed
	always_ff @(posedge clk) begin
		if (accept) begin
			mx_q  <= frame.mouse_x;
			my_q  <= frame.mouse_y;
			mvx_q <= frame.move_x;
			mvy_q <= frame.move_y;
			mvz_q <= frame.move_z;
		end
		if (state_q == S_DX)
			dxp_q <= prod[31:0];
		if (state_q == S_DY)
			dyp_q <= prod[31:0];
		if (state_q == S_ANG)
			red_q <= ysum[31:0];
		else if (state_q == S_MOD)
			red_q <= red_mod;
		if ((state_q == S_CP) && c_done) begin
			cp_q <= c_cos;
			sp_q <= c_sin;
		end
		if ((state_q == S_CY) && c_done) begin
			cy_q <= c_cos;
			sy_q <= c_sin;
		end
		if (state_q == S_F0)
			f0_q <= prod_rnd[29:14];
		if (state_q == S_F2)
			f2_q <= prod_rnd[29:14];
		if (state_q == S_MV) begin
			m_q[0] <= mvec[0];
			m_q[1] <= mvec[1];
			m_q[2] <= mvec[2];
			sq_q   <= '0;
		end
		if (state_q == S_SQ)
			sq_q <= sq_q + prod[fcou_pkg::SQ_W-1:0];
		if ((state_q == S_RWAIT) && rd_done)
			len_q <= rd_res[fcou_pkg::LEN_W-1:0];
		if ((state_q == S_OUT) && (!ov_q || pose.ready)) begin
			opx_q <= pos_q[0];
			opy_q <= pos_q[1];
			opz_q <= pos_q[2];
			ofx_q <= f0_q;
			ofy_q <= sp_q;
			ofz_q <= f2_q;
		end
	end

	assign pose.valid   = ov_q;
	assign pose.pos_x   = opx_q;
	assign pose.pos_y   = opy_q;
	assign pose.pos_z   = opz_q;
	assign pose.front_x = ofx_q;
	assign pose.front_y = ofy_q;
	assign pose.front_z = ofz_q;

	`FCOU_ASSERT_NEXT(a_accept_starts, accept, state_q == S_DX, "accepted frame did not start")
	`FCOU_ASSERT_ALWAYS(a_pitch_clamped, (pitch_q <= fcou_pkg::PITCH_LIMIT) && (pitch_q >= -fcou_pkg::PITCH_LIMIT), "pitch beyond limit")
	`FCOU_ASSERT_ALWAYS(a_yaw_wrapped, (yaw_q >= -fcou_pkg::HALF_TURN) && (yaw_q < fcou_pkg::HALF_TURN), "yaw outside one turn")
	`FCOU_ASSERT_IMP(a_cordic_expected, c_done, (state_q == S_CP) || (state_q == S_CY), "cordic finished outside a wait")
	`FCOU_ASSERT_IMP(a_rootdiv_expected, rd_done, (state_q == S_RWAIT) || (state_q == S_DIV), "root or divide finished outside a wait")

endmodule
